FILE: rtl/core/cic_mass_deposit_grid_core_defines.svh
// Assertion macros shared by the cloud-in-cell deposit core.
// Stands alone; the including module provides clk and rst.
`ifndef CIC_MASS_DEPOSIT_GRID_CORE_DEFINES_SVH
`define CIC_MASS_DEPOSIT_GRID_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMDG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CMDG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/cmdg_pkg.sv
// Shared types and constants of the cloud-in-cell deposit core.
// No dependencies.
`default_nettype none

package cmdg_pkg;

  localparam int ACC_W    = 40;
  localparam int MASS_W   = 24;
  localparam int FRAC_W   = 16;
  localparam int WEIGHT_W = FRAC_W + 1;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(65536);
  localparam logic [ACC_W-1:0]    ACC_MAX = {ACC_W{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_DEPOSIT = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_SCALE_X = 2'd0,
    CFG_SCALE_Y = 2'd1,
    CFG_SCALE_Z = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_idx_t;

  // One axis of a scaled position: integer cell and Q0.16 fraction.
  typedef struct packed {
    logic [31:0]       whole;
    logic [FRAC_W-1:0] frac;
  } axis_split_t;

endpackage

`default_nettype wire

FILE: rtl/core/cmdg_acc_mem.sv
// Accumulator memory: one write port, one read port, registered read data.
// Depends on cmdg_pkg.
`default_nettype none

module cmdg_acc_mem
  import cmdg_pkg::*;
#(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [ACC_W-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [ACC_W-1:0] rdata
);

  logic [ACC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/cmdg_corner_pipe.sv
// Three-stage corner pipeline: weights, node address and corner mass.
// Depends on cmdg_pkg.
`default_nettype none

module cmdg_corner_pipe
  import cmdg_pkg::*;
#(
  parameter int GRID_SIDE = 32,
  parameter int AW3       = 15
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               issue,
  input  wire logic [2:0]         corner,
  input  wire axis_split_t        split_x,
  input  wire axis_split_t        split_y,
  input  wire axis_split_t        split_z,
  input  wire logic [MASS_W-1:0]  mass,
  output logic                    busy,
  output logic                    out_valid,
  output logic [AW3-1:0]          out_addr,
  output logic [ACC_W-1:0]        out_part
);

  localparam logic [31:0]    LAST  = 32'(GRID_SIDE - 1);
  localparam logic [AW3-1:0] ROW   = AW3'(GRID_SIDE);
  localparam logic [AW3-1:0] PLANE = AW3'(GRID_SIDE * GRID_SIDE);

  logic [WEIGHT_W-1:0] wx, wy, wz;
  logic [AW3-1:0]      nx, ny, nz, addr0;

  logic                v1, v2;
  logic [2*WEIGHT_W-1:0] wxy1;
  logic [WEIGHT_W-1:0] wz1, wz2;
  logic [MASS_W-1:0]   mass1;
  logic [AW3-1:0]      addr1, addr2;
  logic [40:0]         a2;

  logic [MASS_W+2*WEIGHT_W-1:0] prod_a;
  logic [40+WEIGHT_W:0]         prod_p;

  function automatic logic [WEIGHT_W-1:0] weight(input logic hi, input logic [FRAC_W-1:0] f);
    logic [WEIGHT_W-1:0] fe;
    fe = {1'b0, f};
    return hi ? fe : ONE_Q16 - fe;
  endfunction

  // Clamp cell or cell+1 to the last node along one axis.
  function automatic logic [AW3-1:0] node(input logic hi, input logic [31:0] c);
    logic [31:0] n;
    if (hi) begin
      n = (c >= LAST) ? LAST : c + 32'd1;
    end else begin
      n = (c > LAST) ? LAST : c;
    end
    return AW3'(n);
  endfunction

  always_comb begin
    wx    = weight(corner[0], split_x.frac);
    wy    = weight(corner[1], split_y.frac);
    wz    = weight(corner[2], split_z.frac);
    nx    = node(corner[0], split_x.whole);
    ny    = node(corner[1], split_y.whole);
    nz    = node(corner[2], split_z.whole);
    addr0 = nx + ny * ROW + nz * PLANE;
    prod_a = MASS_W'(mass1) * (MASS_W+2*WEIGHT_W)'(wxy1);
    prod_p = 58'(a2) * 58'(wz2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= issue;
      v2        <= v1;
      out_valid <= v2;
    end
    wxy1     <= wx * wy;
    wz1      <= wz;
    mass1    <= mass;
    addr1    <= addr0;
    a2       <= prod_a[56:16];
    wz2      <= wz1;
    addr2    <= addr1;
    out_part <= ACC_W'(prod_p[57:32]);
    out_addr <= addr2;
  end

  assign busy = v1 | v2 | out_valid;

endmodule

`default_nettype wire

FILE: rtl/core/cic_mass_deposit_grid_core.sv
// Top level of the cloud-in-cell mass deposit core: sequencer and RMW stage.
// Depends on cmdg_pkg, cmdg_acc_mem, cmdg_corner_pipe and the defines header.
//
//  Channel  Direction  Signals                               Transfer when
//  s_*      in         s_tvalid s_tready s_tdata s_tuser     s_tvalid & s_tready
//  m_*      out        m_tvalid m_tready m_tdata m_tuser     m_tvalid & m_tready
//  cfg_*    in         cfg_valid cfg_ready cfg_index cfg_data cfg_valid & cfg_ready
//
// A deposit runs through the transfer, which also scales the position,
// eight corner issues into the three-stage weight pipeline, a drain until
// the last read-modify-write on the single accumulator memory has landed,
// and the load of the output register. A read steps through the read and
// read-data states and an unused op code goes straight to the result. A
// clear sweeps the memory one entry a cycle over all GRID_SIDE**3 entries;
// the same sweep runs after reset, and no input transfer is taken while it runs.
// The output register lets the next item enter while a result is held by a
// stalled m_tready; a second result then waits in the sequencer.
`default_nettype none
`include "cic_mass_deposit_grid_core_defines.svh"

module cic_mass_deposit_grid_core
  import cmdg_pkg::*;
#(
  parameter int GRID_SIDE = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [135:0] s_tdata,   // pos_x, pos_y, pos_z, particle_mass, node_index
  input  wire logic [1:0]   s_tuser,   // op
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [39:0]       m_tdata,   // node_mass
  output logic              m_tuser,   // saturated
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int NODES = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int AW3   = $clog2(NODES);
  localparam logic [AW3-1:0] LAST_NODE = AW3'(NODES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ISSUE, ST_DRAIN, ST_READ, ST_RDATA, ST_RESULT
  } state_t;

  state_t state;
  logic   accept;
  logic   out_load;

  // Configuration registers.
  logic [31:0] scale_x, scale_y, scale_z;

  // Per-item registers.
  axis_split_t       split_x, split_y, split_z;
  logic [MASS_W-1:0] mass_r;
  logic [AW3-1:0]    node_addr;
  logic              node_ok;
  logic [2:0]        corner;
  logic [AW3-1:0]    clr_cnt;
  logic              clr_result;
  logic              sat_acc;
  logic [ACC_W-1:0]  res_mass;
  logic              res_sat;

  // Scaling products and input decode.
  logic [63:0] prod_x, prod_y, prod_z;
  logic [31:0] idx_wide;

  // Corner pipeline.
  logic               issue;
  logic               pipe_busy, pipe_valid;
  logic [AW3-1:0]     pipe_addr;
  logic [ACC_W-1:0]   pipe_part;

  // Read-modify-write stage and the forwarding of its last write.
  logic               rmw_v;
  logic [AW3-1:0]     rmw_addr;
  logic [ACC_W-1:0]   rmw_part;
  logic               lw_v;
  logic [AW3-1:0]     lw_addr;
  logic [ACC_W-1:0]   lw_data;
  logic [ACC_W-1:0]   base;
  logic [ACC_W:0]     sum;
  logic               ovf;
  logic [ACC_W-1:0]   sum_sat;

  // Memory ports.
  logic               mem_we;
  logic [AW3-1:0]     mem_waddr, mem_raddr;
  logic [ACC_W-1:0]   mem_wdata, mem_rdata;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid & s_tready;
  assign cfg_ready = 1'b1;
  assign issue     = (state == ST_ISSUE);
  // The output register takes a new result when it is empty or being emptied.
  assign out_load  = (state == ST_RESULT) && (!m_tvalid || m_tready);

  always_comb begin
    prod_x   = 64'(s_tdata[31:0]) * 64'(scale_x);
    prod_y   = 64'(s_tdata[63:32]) * 64'(scale_y);
    prod_z   = 64'(s_tdata[95:64]) * 64'(scale_z);
    idx_wide = {17'd0, s_tdata[134:120]};
  end

  // Scale registers; writes must arrive only while the core is idle, which is left to the user to ensure.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x <= 32'd20971;
      scale_y <= 32'd20971;
      scale_z <= 32'd20971;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SCALE_X: scale_x <= cfg_data;
        CFG_SCALE_Y: scale_y <= cfg_data;
        CFG_SCALE_Z: scale_z <= cfg_data;
        default: ;
      endcase
    end
  end

  cmdg_corner_pipe #(
    .GRID_SIDE (GRID_SIDE),
    .AW3       (AW3)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .corner    (corner),
    .split_x   (split_x),
    .split_y   (split_y),
    .split_z   (split_z),
    .mass      (mass_r),
    .busy      (pipe_busy),
    .out_valid (pipe_valid),
    .out_addr  (pipe_addr),
    .out_part  (pipe_part)
  );

  // The memory read for a corner is issued as it leaves the pipeline; the
  // data arrives with the corner in the RMW stage. The write of the corner
  // just before it lands on the same edge as that read, so a match on its
  // address takes the written value instead of the stale read data.
  always_comb begin
    base    = (lw_v && lw_addr == rmw_addr) ? lw_data : mem_rdata;
    sum     = {1'b0, base} + {1'b0, rmw_part};
    ovf     = sum[ACC_W];
    sum_sat = ovf ? ACC_MAX : sum[ACC_W-1:0];

    mem_raddr = (state == ST_READ) ? node_addr : pipe_addr;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else begin
      mem_we    = rmw_v;
      mem_waddr = rmw_addr;
      mem_wdata = sum_sat;
    end
  end

  cmdg_acc_mem #(
    .DEPTH (NODES),
    .AW    (AW3)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rmw_v <= 1'b0;
      lw_v  <= 1'b0;
    end else begin
      rmw_v <= pipe_valid;
      lw_v  <= rmw_v;
    end
    rmw_addr <= pipe_addr;
    rmw_part <= pipe_part;
    lw_addr  <= rmw_addr;
    lw_data  <= sum_sat;
  end

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      clr_result <= 1'b0;
      corner     <= '0;
      sat_acc    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      if (rmw_v && ovf) begin
        sat_acc <= 1'b1;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_cnt == LAST_NODE) begin
            clr_cnt  <= '0;
            res_mass <= '0;
            res_sat  <= 1'b0;
            state    <= clr_result ? ST_RESULT : ST_IDLE;
          end else begin
            clr_cnt <= clr_cnt + AW3'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            split_x   <= '{whole: prod_x[63:32], frac: prod_x[31:16]};
            split_y   <= '{whole: prod_y[63:32], frac: prod_y[31:16]};
            split_z   <= '{whole: prod_z[63:32], frac: prod_z[31:16]};
            mass_r    <= s_tdata[119:96];
            node_addr <= idx_wide[AW3-1:0];
            node_ok   <= (idx_wide < 32'(NODES));
            sat_acc   <= 1'b0;
            corner    <= '0;
            res_mass  <= '0;
            res_sat   <= 1'b0;
            unique case (op_t'(s_tuser))
              OP_CLEAR: begin
                clr_result <= 1'b1;
                state      <= ST_CLEAR;
              end
              OP_DEPOSIT: state <= ST_ISSUE;
              OP_READ:    state <= ST_READ;
              OP_NOP:     state <= ST_RESULT;
              default:    state <= ST_RESULT;
            endcase
          end
        end
        ST_ISSUE: begin
          corner <= corner + 3'd1;
          if (corner == 3'd7) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy && !rmw_v) begin
            res_sat <= sat_acc;
            state   <= ST_RESULT;
          end
        end
        ST_READ: begin
          state <= ST_RDATA;
        end
        ST_RDATA: begin
          res_mass <= node_ok ? mem_rdata : '0;
          state    <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_load) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= res_mass;
            m_tuser    <= res_sat;
            clr_result <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CMDG_ASSERT_NOW(a_read_no_write, (state == ST_READ || state == ST_RDATA), !mem_we, "write during node read")
  `CMDG_ASSERT_NOW(a_result_drained, (state == ST_RESULT), (!rmw_v && !pipe_busy), "result before corners drained")
  `CMDG_ASSERT_NOW(a_clear_blocks, (state == ST_CLEAR), (!s_tready && mem_we), "clear sweep not exclusive")
  `CMDG_ASSERT_NEXT(a_issue_eight, (state == ST_ISSUE && corner == 3'd7), (state == ST_DRAIN && !issue), "corner issue overran")

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for cic_mass_deposit_grid_core: directed, sweep and pile-up tests.
// Depends on cmdg_pkg and the core RTL; it keeps its own copy of the accumulator grid.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cmdg_pkg::*;

  localparam int SIDE      = 32;
  localparam int NODES     = SIDE * SIDE * SIDE;
  // A clear takes a full memory sweep, so the watchdog must outlast one easily.
  localparam int IDLE_LIMIT = 150000;
  localparam int DRAIN_CYCLES = 40;

  // Known values on every input from time zero.
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b1;
  logic [39:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  cic_mass_deposit_grid_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // One expected result: node total and the saturation flag.
  typedef struct packed {
    logic [39:0] node_mass;
    logic        saturated;
  } node_result_t;

  // Predictor state: the scale registers and a shadow of the accumulator grid.
  logic [31:0]  scale_x_q, scale_y_q, scale_z_q;
  logic [39:0]  grid_shadow [NODES];
  node_result_t expected_results [$];
  int           touched_nodes [$];

  int  mismatch_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  deposits_sent = 0;
  int  reads_sent = 0;
  int  sat_seen = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_stalls = 1'b1;
  int  burst_left = 0;
  int  idle_cycles = 0;

  // 20 ns clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver stall pattern: stall_cnt runs through a window of length per_len
  // and m_tready is held low while it is below low_len. The window is redrawn at
  // every wrap so stalls land on every phase of the core's work.
  int stall_cnt = 0;
  int per_len = 7;
  int low_len = 2;
  always @(posedge clk) begin
    if (!receiver_stalls) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= (stall_cnt >= low_len);
      if (stall_cnt + 1 >= per_len) begin
        stall_cnt <= 0;
        per_len <= $urandom_range(1, 12);
        low_len <= $urandom_range(0, 4);
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // Counts cycles with no transfer on any channel; a hang ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAIL cic_mass_deposit_grid_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("mismatch %s at %0t: got %h expected %h", what, $realtime, got, want);
  endtask

  // Every result transfer is compared against the oldest expected result.
  always @(posedge clk) begin
    node_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser) sat_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", {m_tdata, m_tuser}, '0);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata !== want.node_mass) report_mismatch("node_mass", m_tdata, want.node_mass);
        if (m_tuser !== want.saturated) report_mismatch("saturated", m_tuser, want.saturated);
      end
    end
  end

  // Scales one coordinate: integer cell and the top 16 fraction bits of the Q32.32 product.
  function automatic void scale_axis(input logic [31:0] pos, input logic [31:0] scale,
                                     output logic [31:0] whole, output logic [63:0] frac);
    logic [63:0] prod;
    prod = 64'(pos) * 64'(scale);
    whole = prod[63:32];
    frac = 64'(prod[31:16]);
  endfunction

  function automatic int clamp_corner(input logic [31:0] whole, input int step);
    logic [32:0] c;
    c = 33'(whole) + 33'(step);
    return (c > 33'(SIDE - 1)) ? SIDE - 1 : int'(c);
  endfunction

  // Spreads the mass over the eight corners of the cell and updates the shadow.
  // Returns the saturation flag of this deposit.
  function automatic logic predict_deposit(input logic [31:0] px, input logic [31:0] py,
                                           input logic [31:0] pz, input logic [23:0] m);
    logic [31:0] cx, cy, cz;
    logic [63:0] fx, fy, fz, wx, wy, wz, part_a, part;
    logic [40:0] sum;
    int          node;
    logic        sat;
    sat = 1'b0;
    scale_axis(px, scale_x_q, cx, fx);
    scale_axis(py, scale_y_q, cy, fy);
    scale_axis(pz, scale_z_q, cz, fz);
    for (int i = 0; i < 2; i++) begin
      wx = i ? fx : 64'd65536 - fx;
      for (int j = 0; j < 2; j++) begin
        wy = j ? fy : 64'd65536 - fy;
        for (int k = 0; k < 2; k++) begin
          wz = k ? fz : 64'd65536 - fz;
          part_a = (64'(m) * (wx * wy)) >> 16;
          part = (part_a * wz) >> 32;
          node = clamp_corner(cx, i) + clamp_corner(cy, j) * SIDE +
                 clamp_corner(cz, k) * SIDE * SIDE;
          sum = 41'(grid_shadow[node]) + 41'(part);
          if (sum > 41'(ACC_MAX)) begin
            grid_shadow[node] = ACC_MAX;
            sat = 1'b1;
          end else begin
            grid_shadow[node] = sum[39:0];
          end
          if (part != 0) touched_nodes.push_back(node);
        end
      end
    end
    if (touched_nodes.size() > 256) touched_nodes = touched_nodes[$-127:$];
    return sat;
  endfunction

  // Sends one item with the sender's burst and gap idling, and records the
  // expected result at the moment of the transfer. Valid stays high on return
  // so that a following item can go out back to back.
  task automatic send_item(input op_t op, input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] pz, input logic [23:0] m,
                           input logic [14:0] node);
    int           gap;
    node_result_t want;
    if (sender_idles) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, node, m, pz, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = '0;
    case (op)
      OP_CLEAR: begin
        foreach (grid_shadow[n]) grid_shadow[n] = '0;
        touched_nodes.delete();
      end
      OP_DEPOSIT: begin
        want.saturated = predict_deposit(px, py, pz, m);
        deposits_sent++;
      end
      OP_READ: begin
        want.node_mass = grid_shadow[node];
        reads_sent++;
      end
      default: ;
    endcase
    expected_results.push_back(want);
    items_sent++;
  endtask

  // Ends a stream of items and waits until every expected result is back and
  // the core has had time to settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; only called when the core is idle.
  task automatic write_scale(input cfg_idx_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SCALE_X: scale_x_q = value;
      CFG_SCALE_Y: scale_y_q = value;
      CFG_SCALE_Z: scale_z_q = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_scales(input logic [31:0] sx, input logic [31:0] sy,
                            input logic [31:0] sz);
    write_scale(CFG_SCALE_X, sx);
    write_scale(CFG_SCALE_Y, sy);
    write_scale(CFG_SCALE_Z, sz);
  endtask

  task automatic read_node(input int node);
    send_item(OP_READ, '0, '0, '0, '0, 15'(node));
  endtask

  // Corner cases: origin, far clamp, half fractions, zero mass, unused op,
  // the extreme nodes, clear, zero and full-scale registers.
  task automatic test_directed();
    send_item(OP_DEPOSIT, '0, '0, '0, 24'hFFFFFF, '0);
    send_item(OP_DEPOSIT, '1, '1, '1, 24'hFFFFFF, '1);
    send_item(OP_DEPOSIT, 32'h0003_8000, 32'h0001_4000, 32'h0007_C000, 24'h123456, '0);
    send_item(OP_DEPOSIT, 32'h0010_0000, 32'h0020_0000, 32'h0040_0000, 24'h000000, '0);
    send_item(OP_NOP, '1, '1, '1, '1, '1);
    read_node(0);
    read_node(NODES - 1);
    read_node(1);
    read_node(SIDE);
    read_node(SIDE * SIDE);
    read_node(SIDE * SIDE + SIDE + 1);
    send_item(OP_CLEAR, '0, '0, '0, '0, '0);
    read_node(0);
    read_node(NODES - 1);
    wait_idle();
    // Zero scale maps every position onto node zero.
    set_scales('0, '0, '0);
    send_item(OP_DEPOSIT, 32'hDEAD_BEEF, 32'h1234_5678, '1, 24'h800001, '0);
    read_node(0);
    wait_idle();
    // Unit scale: an exact half cell everywhere, then clamped at the far corner.
    set_scales(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_item(OP_DEPOSIT, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 24'hFFFFFF, '0);
    send_item(OP_DEPOSIT, 32'h001F_8000, 32'h001E_8000, 32'h0005_0000, 24'h0FFFFF, '0);
    read_node(1 + SIDE + SIDE * SIDE);
    read_node(31 + 31 * SIDE + 5 * SIDE * SIDE);
    wait_idle();
    set_scales('1, '1, '1);
    send_item(OP_DEPOSIT, 32'h0000_0001, 32'h0000_0002, 32'h0000_0000, 24'h00FFFF, '0);
    read_node(1 + 2 * SIDE);
    wait_idle();
  endtask

  // Random positions, mostly in the populated part of the grid, sometimes fully random.
  function automatic logic [31:0] pick_pos(input logic [31:0] scale);
    logic [63:0] span;
    if ($urandom_range(0, 4) == 0) return $urandom;
    if (scale == 0) return $urandom;
    span = (64'(SIDE + 2) << 32) / 64'(scale);
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    return $urandom_range(0, 32'(span));
  endfunction

  function automatic logic [23:0] pick_mass();
    case ($urandom_range(0, 5))
      0: return 24'hFFFFFF;
      1: return 24'(($urandom_range(0, 255)));
      default: return 24'($urandom);
    endcase
  endfunction

  // Reads mostly hit nodes that recent deposits wrote, so the totals are nonzero.
  task automatic random_items(input int count);
    int sel;
    int node;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 199);
      if (sel == 0) begin
        send_item(OP_CLEAR, $urandom, $urandom, $urandom, 24'($urandom), 15'($urandom));
      end else if (sel < 12) begin
        send_item(OP_NOP, $urandom, $urandom, $urandom, 24'($urandom), 15'($urandom));
      end else if (sel < 130) begin
        send_item(OP_DEPOSIT, pick_pos(scale_x_q), pick_pos(scale_y_q), pick_pos(scale_z_q),
                  pick_mass(), 15'($urandom));
      end else begin
        if (touched_nodes.size() != 0 && $urandom_range(0, 9) < 7)
          node = touched_nodes[$urandom_range(0, touched_nodes.size() - 1)];
        else
          node = $urandom_range(0, NODES - 1);
        send_item(OP_READ, $urandom, $urandom, $urandom, 24'($urandom), 15'(node));
      end
    end
  endtask

  // Several register settings with the extremes among them; one phase runs
  // without any idling on either side.
  task automatic test_scale_sweep();
    set_scales(32'd20971, 32'd20971, 32'd20971);
    random_items(130);
    wait_idle();
    set_scales(32'h0001_0000, 32'h0000_8000, 32'h0002_0000);
    random_items(130);
    wait_idle();
    set_scales('1, 32'h0000_0001, '0);
    random_items(100);
    wait_idle();
    sender_idles = 1'b0;
    receiver_stalls = 1'b0;
    set_scales($urandom, $urandom_range(1, 32'h0004_0000), $urandom_range(1, 32'h0004_0000));
    random_items(120);
    wait_idle();
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
    set_scales($urandom_range(1, 32'h0002_0000), $urandom_range(1, 32'h0002_0000),
               $urandom_range(1, 32'h0002_0000));
    random_items(150);
    wait_idle();
  endtask

  // Piles maximal deposits onto node zero: at zero scale each deposit adds the
  // whole mass there, so the total grows well beyond the 24-bit mass width.
  // Runs without idling to keep the cycle count down.
  task automatic test_pileup();
    set_scales('0, '0, '0);
    sender_idles = 1'b0;
    receiver_stalls = 1'b0;
    send_item(OP_CLEAR, '0, '0, '0, '0, '0);
    for (int n = 0; n < 90; n++)
      send_item(OP_DEPOSIT, $urandom, $urandom, $urandom, 24'hFFFFFF, '0);
    read_node(0);
    read_node(1);
    wait_idle();
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  initial begin
    scale_x_q = 32'd20971;
    scale_y_q = 32'd20971;
    scale_z_q = 32'd20971;
    foreach (grid_shadow[n]) grid_shadow[n] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_scale_sweep();
    test_pileup();
    wait_idle();
    $display("covered %0d items: %0d deposits, %0d reads, %0d results, %0d saturated",
             items_sent, deposits_sent, reads_sent, results_seen, sat_seen);
    $display("register sweep included zero and full-scale settings, %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS cic_mass_deposit_grid_core");
    end else begin
      $display("FAIL cic_mass_deposit_grid_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
